// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHK_ON(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/u16u8_pkg.sv =====
`default_nettype none

package u16u8_pkg;

    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAX_BYTES  = 4;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // UTF-8 lead and continuation markers
    localparam logic [7:0] PFX_CONT  = 8'h80;
    localparam logic [7:0] PFX_TWO   = 8'hC0;
    localparam logic [7:0] PFX_THREE = 8'hE0;
    localparam logic [7:0] PFX_FOUR  = 8'hF0;

    localparam logic [5:0]  SURR_TAG    = 6'b110110; // lead 0xD800..0xDBFF
    localparam logic [5:0]  TRAIL_TAG   = 6'b110111; // trail 0xDC00..0xDFFF
    localparam logic [4:0]  SURR_BLOCK  = 5'b11011;  // 0xD800..0xDFFF
    localparam logic [20:0] SUPP_OFFSET = 21'h10000;

    // One request's worth of results, as handed from front to back.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [MAX_BYTES-1:0]             err;
        logic [1:0]                       last_idx;
        logic                             str_end;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

`default_nettype wire

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder: one UTF-16 code unit per request on the slave side (tlast marks
// the end of a string), UTF-8 bytes one per request on the master side. Each unit is decoded
// in the cycle it is taken and its bytes (1 to 4, or an error marker) are queued as a single
// job in a four-entry queue; while the receiver is ready the back end plays it out one byte
// per cycle. A unit is taken every cycle while the queue has room, so ASCII text runs at one
// unit per cycle; longer outputs stall the input only once the queue fills. A lead surrogate
// not at the end of a string gives nothing until the next unit arrives. Pairing errors give
// a result with tuser[0] set and a zero byte. tlast on the output marks the last result of
// each input unit, tuser[1] the last result of the string.
`default_nettype none

module utf16_to_utf8_transcoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // code_unit
    input  wire         s_axis_tlast,   // string_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser    // bad_surrogate, string_done
);
    import u16u8_pkg::*;

    t_job       push_job;
    t_job       head_job;
    t_fifo_stat stat;
    logic       push;
    logic       pop;

    u16u8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_stat        (stat),
        .o_push        (push),
        .o_job         (push_job)
    );

    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (stat)
    );

    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_stat        (stat),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/u16u8_front.sv =====
`default_nettype none

module u16u8_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [u16u8_pkg::UNIT_W-1:0]       s_axis_tdata,
    input  wire                                s_axis_tlast,
    input  u16u8_pkg::t_fifo_stat              i_stat,
    output logic                               o_push,
    output u16u8_pkg::t_job                    o_job
);
    import u16u8_pkg::*;

    logic       r_pend;
    logic [9:0] r_lead;
    logic       n_pend;
    logic [9:0] n_lead;

    logic        acc;
    logic        is_lead;
    logic        is_trail;
    logic        pair;
    logic [20:0] cp;
    logic [2:0]  n;

    assign s_axis_tready = !i_stat.full;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign is_lead  = (s_axis_tdata[15:10] == SURR_TAG);
    assign is_trail = (s_axis_tdata[15:10] == TRAIL_TAG);
    assign pair     = r_pend && is_trail;
    assign cp       = {1'b0, r_lead, s_axis_tdata[9:0]} + SUPP_OFFSET;

    always_comb begin
        logic [2:0][7:0] cb;
        logic [2:0]      ce;
        logic [1:0]      m;
        cb = '0;
        ce = '0;
        m  = 2'd0;
        o_job = '0;
        if (s_axis_tdata[15:7] == '0) begin
            cb[0] = s_axis_tdata[7:0];
            m     = 2'd1;
        end else if (s_axis_tdata[15:11] == '0) begin
            cb[0] = PFX_TWO | {3'b0, s_axis_tdata[10:6]};
            cb[1] = PFX_CONT | {2'b0, s_axis_tdata[5:0]};
            m     = 2'd2;
        end else if (s_axis_tdata[15:11] != SURR_BLOCK) begin
            cb[0] = PFX_THREE | {4'b0, s_axis_tdata[15:12]};
            cb[1] = PFX_CONT | {2'b0, s_axis_tdata[11:6]};
            cb[2] = PFX_CONT | {2'b0, s_axis_tdata[5:0]};
            m     = 2'd3;
        end else if (is_lead && !s_axis_tlast) begin
            m = 2'd0;   // held, nothing yet
        end else begin
            // lone trail, or lead on the final unit
            ce[0] = 1'b1;
            m     = 2'd1;
        end

        if (pair) begin
            o_job.bytes[0] = PFX_FOUR | {5'b0, cp[20:18]};
            o_job.bytes[1] = PFX_CONT | {2'b0, cp[17:12]};
            o_job.bytes[2] = PFX_CONT | {2'b0, cp[11:6]};
            o_job.bytes[3] = PFX_CONT | {2'b0, cp[5:0]};
            n = 3'd4;
        end else if (r_pend) begin
            // orphaned lead reports first, then the unit itself
            o_job.err[0] = 1'b1;
            for (int i = 0; i < 3; i++) begin
                o_job.bytes[i+1] = cb[i];
                o_job.err[i+1]   = ce[i];
            end
            n = {1'b0, m} + 3'd1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                o_job.bytes[i] = cb[i];
                o_job.err[i]   = ce[i];
            end
            n = {1'b0, m};
        end
        o_job.last_idx = n[1:0] - 2'd1;
        o_job.str_end  = s_axis_tlast;
    end

    assign o_push = acc && (n != 3'd0);

    always_comb begin
        n_pend = r_pend;
        n_lead = r_lead;
        if (acc) begin
            n_pend = !pair && is_lead && !s_axis_tlast;
            n_lead = s_axis_tdata[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
        r_lead <= n_lead;
    end

endmodule

`default_nettype wire

// ===== hdl/u16u8_fifo.sv =====
`default_nettype none

module u16u8_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  u16u8_pkg::t_job        i_job,
    input  wire                    i_pop,
    output u16u8_pkg::t_job        o_job,
    output u16u8_pkg::t_fifo_stat  o_stat
);
    import u16u8_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    t_job               r_head;
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_cnt;
    logic [FIFO_AW-1:0] n_wr;
    logic [FIFO_AW-1:0] n_rd;
    logic [FIFO_CW-1:0] n_cnt;
    logic               wr_en;
    logic               rd_en;

    assign o_stat.full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign wr_en = i_push && !o_stat.full;
    assign rd_en = i_pop && !o_stat.empty;
    assign o_job = r_head;

    always_comb begin
        n_wr  = wr_en ? r_wr + 1'b1 : r_wr;
        n_rd  = rd_en ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (wr_en) begin
            r_mem[r_wr] <= i_job;
        end
        // head slot read ahead; a write landing on it goes straight through
        r_head <= (wr_en && (r_wr == n_rd)) ? i_job : r_mem[n_rd];
    end

endmodule

`default_nettype wire

// ===== hdl/u16u8_back.sv =====
`default_nettype none

module u16u8_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  u16u8_pkg::t_job                 i_job,
    input  u16u8_pkg::t_fifo_stat           i_stat,
    output logic                            o_pop,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [u16u8_pkg::BYTE_W-1:0]    m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic [1:0]                      m_axis_tuser
);
    import u16u8_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    t_job       n_job;
    logic       n_busy;
    logic [1:0] n_idx;

    logic take;
    logic last;

    assign last = (r_idx == r_job.last_idx);
    assign take = r_busy && m_axis_tready;
    assign o_pop = (!r_busy || (take && last)) && !i_stat.empty;

    assign m_axis_tvalid   = r_busy;
    assign m_axis_tdata    = r_job.bytes[r_idx];
    assign m_axis_tlast    = last;
    assign m_axis_tuser[0] = r_job.err[r_idx];
    assign m_axis_tuser[1] = last && r_job.str_end;

    always_comb begin
        n_job  = r_job;
        n_busy = r_busy;
        n_idx  = r_idx;
        priority if (o_pop) begin
            n_job  = i_job;
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (take && last) begin
            n_busy = 1'b0;
        end else if (take) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_job <= n_job;
    end

endmodule

`default_nettype wire

// ===== hdl/u16u8_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module u16u8_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [15:0] s_axis_tdata,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [7:0]  m_axis_tdata,
    input wire        m_axis_tlast,
    input wire [1:0]  m_axis_tuser
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tlast;

    // stalled output request holds
    `CHK_ON(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output changed while stalled")

    // error marker carries no byte
    `CHK_ON(a_err_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00, "error result with non-zero byte")

    // end of string only on the last result of a unit
    `CHK_ON(a_done_last, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast, "string end without tlast")

    // nothing offered right after reset
    `CHK_ALWAYS(a_rst_quiet, $past(!i_rst_n) |-> !m_axis_tvalid, "output valid after reset")

endmodule

bind utf16_to_utf8_transcoder u16u8_chk u_chk (.*);

`default_nettype wire

// ===== tb/utf16_to_utf8_transcoder_test.sv =====
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_test;

    localparam logic [5:0]  LEAD_TAG  = 6'b110110;
    localparam logic [5:0]  TRAIL_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [7:0]  CONT_MARK = 8'h80;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       bad_surrogate;
        logic       string_done;
    } t_utf8_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_BURSTY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // code_unit
    logic        s_axis_tlast = 1'b0;  // string_end
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [7:0]  m_axis_tdata;         // out_byte
    wire         m_axis_tlast;         // run_last
    wire  [1:0]  m_axis_tuser;         // bad_surrogate, string_done

    utf16_to_utf8_transcoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state and the bytes still owed by the block
    logic         held_lead = 1'b0;
    logic [9:0]   held_bits = '0;
    t_utf8_result pending_bytes [$];
    int           error_count = 0;
    int           units_sent = 0;
    int           burst_left = 0;

    function automatic t_utf8_result plain_byte(input logic [7:0] b, input logic err);
        t_utf8_result r;
        r.out_byte      = b;
        r.run_last      = 1'b0;
        r.bad_surrogate = err;
        r.string_done   = 1'b0;
        return r;
    endfunction

    function automatic void encode_unit(input logic [15:0] cu, input logic eos);
        t_utf8_result res [4];
        int           n;
        logic [20:0]  cp;
        logic         is_lead;
        logic         is_trail;
        n        = 0;
        is_lead  = (cu[15:10] == LEAD_TAG);
        is_trail = (cu[15:10] == TRAIL_TAG);
        if (held_lead && is_trail) begin
            cp = {1'b0, held_bits, cu[9:0]} + SUPP_BASE;
            held_lead = 1'b0;
            held_bits = '0;
            res[0] = plain_byte(8'hF0 | {5'd0, cp[20:18]}, 1'b0);
            res[1] = plain_byte(CONT_MARK | {2'd0, cp[17:12]}, 1'b0);
            res[2] = plain_byte(CONT_MARK | {2'd0, cp[11:6]}, 1'b0);
            res[3] = plain_byte(CONT_MARK | {2'd0, cp[5:0]}, 1'b0);
            n = 4;
        end else begin
            if (held_lead) begin
                // held lead broken by a non-trail
                res[n] = plain_byte(8'h00, 1'b1);
                n++;
                held_lead = 1'b0;
                held_bits = '0;
            end
            if (cu <= 16'h007F) begin
                res[n] = plain_byte(cu[7:0], 1'b0);
                n++;
            end else if (cu <= 16'h07FF) begin
                res[n]   = plain_byte(8'hC0 | {3'd0, cu[10:6]}, 1'b0);
                res[n+1] = plain_byte(CONT_MARK | {2'd0, cu[5:0]}, 1'b0);
                n += 2;
            end else if (cu[15:11] != LEAD_TAG[5:1]) begin
                res[n]   = plain_byte(8'hE0 | {4'd0, cu[15:12]}, 1'b0);
                res[n+1] = plain_byte(CONT_MARK | {2'd0, cu[11:6]}, 1'b0);
                res[n+2] = plain_byte(CONT_MARK | {2'd0, cu[5:0]}, 1'b0);
                n += 3;
            end else if (is_lead) begin
                if (eos) begin
                    res[n] = plain_byte(8'h00, 1'b1);
                    n++;
                end else begin
                    held_lead = 1'b1;
                    held_bits = cu[9:0];
                end
            end else begin
                res[n] = plain_byte(8'h00, 1'b1);
                n++;
            end
        end
        if (n > 0) begin
            res[n-1].run_last    = 1'b1;
            res[n-1].string_done = eos;
        end
        for (int k = 0; k < n; k++) pending_bytes.push_back(res[k]);
    endfunction

    // both sides sampled at the edge, before any of this edge's updates land
    always @(posedge i_clk) begin
        t_utf8_result got;
        t_utf8_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) encode_unit(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte      = m_axis_tdata;
                got.run_last      = m_axis_tlast;
                got.bad_surrogate = m_axis_tuser[0];
                got.string_done   = m_axis_tuser[1];
                if (pending_bytes.size() == 0) begin
                    $display("%0t: unexpected result byte=%h last=%b err=%b done=%b", $time,
                             got.out_byte, got.run_last, got.bad_surrogate, got.string_done);
                    error_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected byte=%h last=%b err=%b done=%b, got byte=%h last=%b err=%b done=%b",
                                 $time, want.out_byte, want.run_last, want.bad_surrogate,
                                 want.string_done, got.out_byte, got.run_last,
                                 got.bad_surrogate, got.string_done);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver backpressure in one of four stall patterns, re-picked at random
    t_rx_mode   rx_mode = RX_ALWAYS;
    int         rx_phase = 0;
    logic [7:0] rx_count = '0;

    always @(posedge i_clk) begin
        rx_count <= rx_count + 8'd1;
        if (rx_phase == 0) begin
            rx_mode  <= t_rx_mode'($urandom_range(0, 3));
            rx_phase <= $urandom_range(16, 80);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_ALWAYS:      m_axis_tready <= 1'b1;
            RX_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: m_axis_tready <= (rx_count[1:0] == 2'd0);
            default:        m_axis_tready <= !rx_count[2];
        endcase
    end

    // entered and left at a rising edge; valid stays high between back-to-back requests
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cu;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        units_sent++;
    endtask

    task automatic stream_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_bmp_ranges();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b1);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
    endtask

    task automatic test_surrogate_pairs();
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // pair completed by an end-marked trail
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDC37, 1'b1);
    endtask

    task automatic test_pairing_errors();
        // lone trails
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // lead broken by ASCII, then by another lead which then pairs
        send_unit(16'hD83D, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC00, 1'b1);
        // lead at end of string, alone and after a held lead
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDA00, 1'b1);
    endtask

    task automatic send_random_char(input logic eos);
        int          pick;
        logic [15:0] v;
        logic [9:0]  hi;
        logic [9:0]  lo;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_unit(16'($urandom_range(16'h0000, 16'h007F)), eos);
        end else if (pick < 45) begin
            send_unit(16'($urandom_range(16'h0080, 16'h07FF)), eos);
        end else if (pick < 65) begin
            v = 16'($urandom_range(16'h0800, 16'hF7FF));
            if (v >= 16'hD800) v = v + 16'h0800;
            send_unit(v, eos);
        end else if (pick < 88) begin
            hi = 10'($urandom);
            lo = 10'($urandom);
            send_unit({LEAD_TAG, hi}, 1'b0);
            send_unit({TRAIL_TAG, lo}, eos);
        end else if (pick < 92) begin
            send_unit({TRAIL_TAG, 10'($urandom)}, eos);
        end else if (pick < 96) begin
            send_unit({LEAD_TAG, 10'($urandom)}, eos);
        end else begin
            send_unit(16'($urandom), eos);
        end
    endtask

    task automatic test_random_strings(input int target);
        int len;
        while (units_sent < target) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) send_random_char(k == len - 1);
        end
    endtask

    // stop the sender until the block has caught up completely, then resume
    task automatic test_drain_pause();
        stream_idle();
        wait_drained();
        repeat ($urandom_range(2, 10)) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bmp_ranges();
        test_surrogate_pairs();
        test_pairing_errors();
        test_random_strings(units_sent + 155);
        test_drain_pause();
        test_random_strings(units_sent + 160);
        stream_idle();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("utf16_to_utf8_transcoder verification clean");
        end else begin
            $display("utf16_to_utf8_transcoder verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("utf16_to_utf8_transcoder verification failed");
        $finish;
    end

endmodule
